// ----- rtl/assert_macros.svh -----
// Assertion macros used by the decoder controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/ucrd_pkg.sv -----
// Shared types and constants of the spent-coin record decoder.
package ucrd_pkg;
  localparam int MAX_SCRIPT_LEN = 16383;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_KEY = 2'd1;
  localparam logic [1:0] ERR_LONG = 2'd2;
  localparam logic [1:0] ERR_VARINT = 2'd3;

  localparam logic [2:0] TK_P2PKH = 3'd0;
  localparam logic [2:0] TK_P2SH = 3'd1;
  localparam logic [2:0] TK_P2PK2 = 3'd2;
  localparam logic [2:0] TK_P2PK3 = 3'd3;
  localparam logic [2:0] TK_RAW = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [62:0] height;
    logic        is_coinbase;
    logic [63:0] amount;
    logic [14:0] stype_code;
    logic [7:0]  script_byte;
    logic        last;
    logic [1:0]  error_code;
  } out_item_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic clear;        // clear record registers
    logic acc_byte;     // shift the byte into the varint accumulator
    logic store_height; // take the finished varint as height code
    logic amt_start;    // start amount expansion of the finished varint
    logic store_stype;  // take the finished varint as script type
    logic set_tmpl;     // set template and remaining count from stype
    logic dec_rem;      // count one script byte down
  } dp_cmd_t;

  typedef struct packed {
    logic [63:0] vdone;     // accumulator value including current byte
    logic [3:0]  vcount;    // bytes so far including current
    logic        amt_busy;
    logic [14:0] rem;
    logic [2:0]  tmpl;
    logic [14:0] stype;
    logic [62:0] height;
    logic        coinbase;
    logic [63:0] amount;
  } dp_stat_t;
endpackage

// ----- rtl/ucrd_if.sv -----
// Valid/ready channel interfaces of the decoder.
interface ucrd_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_record;
  modport source (output valid, data_byte, first_of_record, input ready);
  modport sink (input valid, data_byte, first_of_record, output ready);
endinterface

interface ucrd_out_if (input logic clk);
  logic              valid;
  logic              ready;
  ucrd_pkg::out_item_t item;
  modport source (output valid, item, input ready);
  modport sink (input valid, item, output ready);
endinterface

// ----- rtl/undo_coin_record_decoder.sv -----
// Top level of the spent-coin record decoder.
// Output: the results of a byte start the cycle after its accepting edge, one a cycle
// while the output is ready. Throughput: one byte a cycle while parsing; a byte with one
// to four results holds the input until each result transaction has been taken. The final
// amount byte holds it while the amount is divided by ten, by nine unless the remainder is nine, then scaled by ten.
// Reset (rst_n low, synchronous) returns the parser to awaiting a height code.
module undo_coin_record_decoder (
  input  logic      clk,
  input  logic      rst_n,
  ucrd_in_if.sink    in_ch,
  ucrd_out_if.source out_ch
);
  ucrd_pkg::dp_cmd_t  cmd;
  ucrd_pkg::dp_stat_t stat;

  // The controller owns the handshakes; the datapath holds the record.
  ucrd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cmd(cmd), .stat(stat)
  );
  ucrd_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .data_byte(in_ch.data_byte), .cmd(cmd), .stat(stat)
  );
endmodule

// ----- rtl/ucrd_datapath.sv -----
// Datapath: varint accumulator, record registers and amount expansion.
module ucrd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        data_byte,
  input  ucrd_pkg::dp_cmd_t cmd,
  output ucrd_pkg::dp_stat_t stat
);
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_base;
  logic [3:0]  cnt_base;
  logic [62:0] height_r;
  logic        cb_r;
  logic [63:0] amount_r;
  logic [14:0] stype_r;
  logic [2:0]  tmpl_r;
  logic [14:0] rem_r;
  // Amount expansion sequencer: x-1 is divided by ten, then by nine unless the remainder
  // is nine, sixteen bits a cycle from the top, then scaled by ten once a cycle.
  logic [2:0]  aph_r;
  logic [63:0] ax_r;
  logic [63:0] aq_r;
  logic [3:0]  ar_r;
  logic [1:0]  ach_r;
  logic [3:0]  ae_r;
  logic [19:0] dcur;
  logic [19:0] dmul;
  logic [39:0] dprod;
  logic [15:0] dq;
  logic [19:0] dqm;
  logic [19:0] ddiff;
  logic [3:0]  dr;
  logic [63:0] dquot;
  logic [63:0] sh;

  localparam logic [2:0] AP_IDLE = 3'd0;
  localparam logic [2:0] AP_D10 = 3'd1;
  localparam logic [2:0] AP_D9 = 3'd2;
  localparam logic [2:0] AP_MUL = 3'd3;

  // Reciprocals scaled by 2^23; exact for the 20-bit partial dividends used.
  localparam logic [19:0] DIV10_RECIP = 20'hCCCCD;
  localparam logic [19:0] DIV9_RECIP = 20'hE38E4;

  // A record start clears the accumulator before the byte is shifted in.
  always_comb begin
    acc_base = cmd.clear ? 64'd0 : acc_r;
    cnt_base = cmd.clear ? 4'd0 : cnt_r;
  end
  assign sh = {acc_base[56:0], data_byte[6:0]};
  always_comb begin
    acc_nxt = sh + {63'd0, data_byte[7]};
    cnt_nxt = cnt_base + 4'd1;
  end

  // One sixteen-bit digit of the long division by ten or nine.
  always_comb begin
    dcur = {ar_r, ax_r[63:48]};
    dmul = (aph_r == AP_D9) ? DIV9_RECIP : DIV10_RECIP;
    dprod = {20'd0, dcur} * {20'd0, dmul};
    dq = dprod[38:23];
    if (aph_r == AP_D9) begin
      dqm = {1'b0, dq, 3'd0} + {4'd0, dq};
    end else begin
      dqm = {1'b0, dq, 3'd0} + {3'd0, dq, 1'b0};
    end
    ddiff = dcur - dqm;
    dr = ddiff[3:0];
    dquot = {aq_r[47:0], dq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aph_r <= AP_IDLE;
      amount_r <= 64'd0;
    end else if (cmd.clear) begin
      amount_r <= 64'd0;
    end else begin
      unique case (aph_r)
        AP_IDLE: if (cmd.amt_start) begin
          if (sh == 64'd0) begin
            amount_r <= 64'd0;
          end else begin
            ax_r <= sh - 64'd1;
            aq_r <= 64'd0;
            ar_r <= 4'd0;
            ach_r <= 2'd0;
            aph_r <= AP_D10;
          end
        end
        AP_D10: begin
          ach_r <= ach_r + 2'd1;
          if (ach_r != 2'd3) begin
            ax_r <= {ax_r[47:0], 16'd0};
            aq_r <= dquot;
            ar_r <= dr;
          end else begin
            ae_r <= dr;
            ax_r <= dquot;
            aq_r <= 64'd0;
            ar_r <= 4'd0;
            if (dr == 4'd9) begin
              amount_r <= dquot + 64'd1;
              aph_r <= AP_MUL;
            end else begin
              aph_r <= AP_D9;
            end
          end
        end
        AP_D9: begin
          ach_r <= ach_r + 2'd1;
          if (ach_r != 2'd3) begin
            ax_r <= {ax_r[47:0], 16'd0};
            aq_r <= dquot;
            ar_r <= dr;
          end else begin
            amount_r <= {dquot[60:0], 3'd0} + {dquot[62:0], 1'b0} + {60'd0, dr} + 64'd1;
            aph_r <= AP_MUL;
          end
        end
        AP_MUL: begin
          if (ae_r == 4'd0) begin
            aph_r <= AP_IDLE;
          end else begin
            amount_r <= {amount_r[60:0], 3'd0} + {amount_r[62:0], 1'b0};
            ae_r <= ae_r - 4'd1;
          end
        end
        default: aph_r <= AP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0; cnt_r <= '0; height_r <= '0; cb_r <= 1'b0;
      stype_r <= '0; tmpl_r <= '0; rem_r <= '0;
    end else begin
      if (cmd.acc_byte) begin
        if (data_byte[7]) begin
          acc_r <= acc_nxt; cnt_r <= cnt_nxt;
        end else begin
          acc_r <= '0; cnt_r <= '0;
        end
      end else if (cmd.clear) begin
        acc_r <= '0; cnt_r <= '0;
      end
      if (cmd.store_height) begin
        height_r <= sh[63:1]; cb_r <= sh[0];
      end else if (cmd.clear) begin
        height_r <= '0; cb_r <= 1'b0;
      end
      if (cmd.store_stype) begin
        stype_r <= sh[14:0];
      end else if (cmd.clear) begin
        stype_r <= '0;
      end
      if (cmd.set_tmpl) begin
        if (sh >= 64'd6) begin
          tmpl_r <= ucrd_pkg::TK_RAW; rem_r <= 15'(sh - 64'd6);
        end else begin
          tmpl_r <= sh[2:0];
          rem_r <= (sh[1]) ? 15'd32 : 15'd20;
        end
      end else if (cmd.dec_rem) begin
        rem_r <= rem_r - 15'd1;
      end else if (cmd.clear) begin
        tmpl_r <= '0; rem_r <= '0;
      end
    end
  end

  always_comb begin
    stat.vdone = sh;
    stat.vcount = cnt_nxt;
    stat.amt_busy = (aph_r != AP_IDLE);
    stat.rem = rem_r;
    stat.tmpl = tmpl_r;
    stat.stype = stype_r;
    stat.height = height_r;
    stat.coinbase = cb_r;
    stat.amount = amount_r;
  end
endmodule

// ----- rtl/ucrd_ctrl.sv -----
// Controller: field phases and result sequencing.
`include "assert_macros.svh"
module ucrd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  ucrd_in_if.sink            in_ch,
  ucrd_out_if.source         out_ch,
  output ucrd_pkg::dp_cmd_t  cmd,
  input  ucrd_pkg::dp_stat_t stat
);
  localparam logic [2:0] PH_HCODE = 3'd0;
  localparam logic [2:0] PH_DUMMY = 3'd1;
  localparam logic [2:0] PH_AMOUNT = 3'd2;
  localparam logic [2:0] PH_STYPE = 3'd3;
  localparam logic [2:0] PH_SCRIPT = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_EMIT = 3'd6;

  logic [2:0] ph_r, ph_nxt, ret_r, ret_nxt;
  // queue of pending result items (header/byte/error descriptors)
  logic [3:0][1:0] qk_r, qk_nxt;
  logic [3:0][7:0] qb_r, qb_nxt;
  logic [3:0]      ql_r, ql_nxt;
  logic [3:0][1:0] qe_r, qe_nxt;
  logic [2:0]      qn_r, qn_nxt;
  logic [14:0]     est_r, est_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      b;
  logic            take, pop;
  logic [2:0]      k;

  assign b = in_ch.data_byte;
  assign in_ch.ready = (ph_r != PH_EMIT) && !stat.amt_busy && !ov_r;
  assign take = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov_r;
  assign pop = ov_r && out_ch.ready;

  always_comb begin
    out_ch.item.kind = qk_r[0];
    out_ch.item.height = stat.height;
    out_ch.item.is_coinbase = stat.coinbase;
    out_ch.item.amount = stat.amount;
    out_ch.item.stype_code = est_r;
    out_ch.item.script_byte = qb_r[0];
    out_ch.item.last = ql_r[0];
    out_ch.item.error_code = qe_r[0];
  end

  always_comb begin
    ph_nxt = ph_r; ret_nxt = ret_r;
    qk_nxt = qk_r; qb_nxt = qb_r; ql_nxt = ql_r; qe_nxt = qe_r; qn_nxt = qn_r;
    est_nxt = est_r; ov_nxt = ov_r;
    cmd = '0;
    k = 3'd0;
    if (pop) begin
      qk_nxt = {2'd0, qk_r[3:1]}; qb_nxt = {8'd0, qb_r[3:1]};
      ql_nxt = {1'b0, ql_r[3:1]}; qe_nxt = {2'd0, qe_r[3:1]};
      qn_nxt = qn_r - 3'd1;
      ov_nxt = (qn_r > 3'd1);
      if (qn_r == 3'd1) ph_nxt = ret_r;
    end
    if (take) begin
      if (in_ch.first_of_record) cmd.clear = 1'b1;
      qn_nxt = 3'd0;
      unique case (in_ch.first_of_record ? PH_HCODE : ph_r)
        PH_DUMMY: ph_nxt = PH_AMOUNT;
        PH_SCRIPT: begin
          cmd.dec_rem = 1'b1;
          qk_nxt[0] = ucrd_pkg::KIND_BYTE; qb_nxt[0] = b; qe_nxt = '0; ql_nxt = '0;
          k = 3'd1;
          if (stat.rem == 15'd1) begin
            ret_nxt = PH_DONE;
            unique case (stat.tmpl)
              ucrd_pkg::TK_P2PKH: begin
                qk_nxt[1] = ucrd_pkg::KIND_BYTE; qb_nxt[1] = 8'h88;
                qk_nxt[2] = ucrd_pkg::KIND_BYTE; qb_nxt[2] = 8'hac; ql_nxt[2] = 1'b1;
                k = 3'd3;
              end
              ucrd_pkg::TK_P2SH: begin
                qk_nxt[1] = ucrd_pkg::KIND_BYTE; qb_nxt[1] = 8'h87; ql_nxt[1] = 1'b1;
                k = 3'd2;
              end
              ucrd_pkg::TK_P2PK2, ucrd_pkg::TK_P2PK3: begin
                qk_nxt[1] = ucrd_pkg::KIND_BYTE; qb_nxt[1] = 8'hac; ql_nxt[1] = 1'b1;
                k = 3'd2;
              end
              default: ql_nxt[0] = 1'b1;
            endcase
          end else begin
            ret_nxt = PH_SCRIPT;
          end
        end
        PH_HCODE, PH_AMOUNT, PH_STYPE: begin
          cmd.acc_byte = 1'b1;
          if (b[7]) begin
            if (stat.vcount >= 4'd10) begin
              qk_nxt[0] = ucrd_pkg::KIND_ERR; qb_nxt[0] = 8'd0; ql_nxt[0] = 1'b1;
              qe_nxt[0] = ucrd_pkg::ERR_VARINT; est_nxt = 15'd0;
              k = 3'd1; ret_nxt = PH_DONE;
            end else if (in_ch.first_of_record) begin
              ph_nxt = PH_HCODE;
            end
          end else if ((in_ch.first_of_record ? PH_HCODE : ph_r) == PH_HCODE) begin
            cmd.store_height = 1'b1;
            ph_nxt = (stat.vdone[63:1] != 63'd0) ? PH_DUMMY : PH_AMOUNT;
          end else if (ph_r == PH_AMOUNT) begin
            cmd.amt_start = 1'b1;
            ph_nxt = PH_STYPE;
          end else begin
            cmd.store_stype = 1'b1; cmd.set_tmpl = 1'b1;
            qb_nxt = '0; qe_nxt = '0; ql_nxt = '0;
            qk_nxt[0] = ucrd_pkg::KIND_HDR; est_nxt = stat.vdone[14:0];
            if (stat.vdone == 64'd4 || stat.vdone == 64'd5) begin
              qk_nxt[1] = ucrd_pkg::KIND_ERR; ql_nxt[1] = 1'b1;
              qe_nxt[1] = ucrd_pkg::ERR_KEY;
              k = 3'd2; ret_nxt = PH_DONE;
            end else if (stat.vdone >= 64'd6) begin
              if (stat.vdone - 64'd6 > 64'(ucrd_pkg::MAX_SCRIPT_LEN)) begin
                qk_nxt[0] = ucrd_pkg::KIND_ERR; ql_nxt[0] = 1'b1;
                qe_nxt[0] = ucrd_pkg::ERR_LONG; est_nxt = 15'd0;
                ret_nxt = PH_DONE;
              end else if (stat.vdone == 64'd6) begin
                ql_nxt[0] = 1'b1; ret_nxt = PH_DONE;
              end else begin
                ret_nxt = PH_SCRIPT;
              end
              k = 3'd1;
            end else if (stat.vdone == 64'd0) begin
              qk_nxt[1] = ucrd_pkg::KIND_BYTE; qb_nxt[1] = 8'h76;
              qk_nxt[2] = ucrd_pkg::KIND_BYTE; qb_nxt[2] = 8'ha9;
              qk_nxt[3] = ucrd_pkg::KIND_BYTE; qb_nxt[3] = 8'h14;
              k = 3'd4; ret_nxt = PH_SCRIPT;
            end else if (stat.vdone == 64'd1) begin
              qk_nxt[1] = ucrd_pkg::KIND_BYTE; qb_nxt[1] = 8'ha9;
              qk_nxt[2] = ucrd_pkg::KIND_BYTE; qb_nxt[2] = 8'h14;
              k = 3'd3; ret_nxt = PH_SCRIPT;
            end else begin
              qk_nxt[1] = ucrd_pkg::KIND_BYTE; qb_nxt[1] = 8'h21;
              qk_nxt[2] = ucrd_pkg::KIND_BYTE; qb_nxt[2] = stat.vdone[7:0];
              k = 3'd3; ret_nxt = PH_SCRIPT;
            end
          end
        end
        default: ;
      endcase
      if (k != 3'd0) begin
        qn_nxt = k; ov_nxt = 1'b1; ph_nxt = PH_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HCODE; ret_r <= PH_HCODE; qn_r <= 3'd0; ov_r <= 1'b0;
      est_r <= 15'd0;
    end else begin
      ph_r <= ph_nxt; ret_r <= ret_nxt; qn_r <= qn_nxt; ov_r <= ov_nxt;
      est_r <= cmd.clear && (k == 3'd0) ? 15'd0 : est_nxt;
    end
  end
  always_ff @(posedge clk) begin
    qk_r <= qk_nxt; qb_r <= qb_nxt; ql_r <= ql_nxt; qe_r <= qe_nxt;
  end

  `ASSERT_ALWAYS(a_valid_count, clk, rst_n, ov_r == (qn_r != 3'd0), "valid disagrees with queue")
  `ASSERT_ALWAYS(a_no_take_emit, clk, rst_n, !(take && ov_r), "byte taken while emitting")
  `ASSERT_NEXT(a_last_done, clk, rst_n, pop && ql_r[0] && qn_r == 3'd1, ph_r == PH_DONE, "last item did not end record")
endmodule
